>>> rtl/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared widths, command codes, sequencer states and the control structs
// that pass between the allocator top level and its header walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ifla_pkg;

  localparam int CMD_W = 2;
  localparam int REQ_W = 15;
  localparam int OFF_W = 15;
  localparam int LFB_W = 16;
  localparam int CFG_W = 16;

  localparam int UNIT_BYTES = 8;
  localparam int UNIT_SHIFT = 3;
  localparam int MIN_UNITS = 2;
  localparam int POOL_BYTES_RESET = 32768;

  // Widest block need: largest request plus header, rounded up to units
  localparam int NEED_W = 13;
  // Unit index of a payload offset, less one for the header
  localparam int TGT_W = OFF_W - UNIT_SHIFT;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OPTIMIZE = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_HDR,
    ST_GROW,
    ST_GHDR,
    ST_SPLIT,
    ST_MARK,
    ST_FWALK,
    ST_FHDR,
    ST_FNXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic [CFG_W-1:0] pool_bytes;
    logic start;
    logic [CMD_W-1:0] command;
    logic [NEED_W-1:0] need;
    logic [TGT_W-1:0] target;
    logic target_ok;
  } job_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
    logic found;
    logic [OFF_W-1:0] offset;
    logic [LFB_W-1:0] largest;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/ifla_if.sv
// ----------------------------------------------------------------------------
// ifla channel interfaces
// Valid/ready channels for command beats, result beats and pool size writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifla_cmd_if;
  import ifla_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] payload_offset;
  modport source (output valid, output command, output request_bytes,
                  output payload_offset, input ready);
  modport sink (input valid, input command, input request_bytes,
                input payload_offset, output ready);
endinterface

interface ifla_rsp_if;
  import ifla_pkg::*;
  logic valid;
  logic ready;
  logic found;
  logic [OFF_W-1:0] granted_offset;
  logic [LFB_W-1:0] largest_free_bytes;
  modport source (output valid, output found, output granted_offset,
                  output largest_free_bytes, input ready);
  modport sink (input valid, input found, input granted_offset,
                input largest_free_bytes, output ready);
endinterface

interface ifla_cfg_if;
  import ifla_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_W-1:0] pool_bytes;
  modport source (output valid, output pool_bytes, input ready);
  modport sink (input valid, input pool_bytes, output ready);
endinterface

`default_nettype wire

>>> rtl/ifla_ram.sv
// ----------------------------------------------------------------------------
// ifla_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ifla_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ifla_walker.sv
// ----------------------------------------------------------------------------
// ifla_walker
// Header sequencer: walks, merges, splits and marks block headers held in
// the header RAM, one header read per visit.
// ----------------------------------------------------------------------------
`default_nettype none

module ifla_walker #(
  parameter int POOL_UNITS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ifla_pkg::job_t    job,
  input  wire logic              res_take,
  output ifla_pkg::status_t      status
);
  import ifla_pkg::*;

  localparam int SW = $clog2(POOL_UNITS + 1);
  localparam int AW = $clog2(POOL_UNITS);
  localparam int DW = SW + 1;
  localparam int CW = (SW > NEED_W) ? SW : NEED_W;
  localparam int PW = CW + 1;
  localparam int RESET_UNITS_RAW = POOL_BYTES_RESET / UNIT_BYTES;
  localparam int RESET_UNITS = (RESET_UNITS_RAW > POOL_UNITS) ? POOL_UNITS : RESET_UNITS_RAW;

  state_t state, state_next;
  logic [CMD_W-1:0] op, op_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] cur, cur_next;
  logic [PW-1:0] goal, goal_next;
  logic [PW-1:0] best, best_next;
  logic [PW-1:0] target, target_next;
  logic [PW-1:0] units, units_next;
  logic res_found, res_found_next;
  logic [OFF_W-1:0] res_offset, res_offset_next;
  logic [LFB_W-1:0] res_largest, res_largest_next;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic rd_used;
  logic [PW-1:0] rd_size;
  logic [PW-1:0] nx_grow;
  logic [PW-1:0] nx_free;
  logic [PW-1:0] merged;
  logic [PW-1:0] remain;
  logic [PW-1:0] split_at;
  logic [PW-1:0] pos_cur;
  logic [PW-1:0] pos_rd;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] best_max;
  logic [PW-1:0] cfg_raw;
  logic [PW-1:0] cfg_units;
  logic [PW+UNIT_SHIFT-1:0] offset_wide;
  logic [PW+UNIT_SHIFT-1:0] largest_wide;

  assign rd_used = mem_rdata[0];
  assign rd_size = PW'(mem_rdata[DW-1:1]);
  assign nx_grow = pos + cur;
  assign nx_free = pos + rd_size;
  assign merged = cur + rd_size;
  assign remain = cur - goal;
  assign split_at = pos + goal;
  assign pos_cur = pos + cur;
  assign pos_rd = pos + rd_size;
  assign pos_inc = pos + PW'(1);
  assign best_max = (cur > best) ? cur : best;
  assign offset_wide = {pos_inc, {UNIT_SHIFT{1'b0}}};
  assign largest_wide = {best, {UNIT_SHIFT{1'b0}}};

  assign cfg_raw = PW'(job.pool_bytes >> UNIT_SHIFT);
  assign cfg_units = (cfg_raw < PW'(MIN_UNITS)) ? PW'(MIN_UNITS) :
                     (cfg_raw > PW'(POOL_UNITS)) ? PW'(POOL_UNITS) : cfg_raw;

  ifla_ram #(
    .WIDTH (DW),
    .DEPTH (POOL_UNITS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state and working registers
  always_comb begin
    state_next = state;
    op_next = op;
    pos_next = pos;
    cur_next = cur;
    goal_next = goal;
    best_next = best;
    target_next = target;
    units_next = units;
    res_found_next = res_found;
    res_offset_next = res_offset;
    res_largest_next = res_largest;
    case (state)
      ST_INIT: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (job.cfg_we) begin
          units_next = cfg_units;
        end else if (job.start) begin
          op_next = job.command;
          pos_next = '0;
          best_next = '0;
          target_next = PW'(job.target);
          res_found_next = 1'b0;
          res_offset_next = '0;
          res_largest_next = '0;
          case (job.command)
            CMD_ALLOC: begin
              goal_next = PW'(job.need);
              state_next = ST_WALK;
            end
            CMD_FREE: begin
              state_next = job.target_ok ? ST_FWALK : ST_DONE;
            end
            CMD_OPTIMIZE: begin
              goal_next = units;
              state_next = ST_WALK;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (pos >= units) begin
          if (op == CMD_OPTIMIZE) begin
            res_largest_next = largest_wide[LFB_W-1:0];
          end
          state_next = ST_DONE;
        end else begin
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        if (rd_size == '0) begin
          state_next = ST_DONE;
        end else if (rd_used) begin
          pos_next = pos_rd;
          state_next = ST_WALK;
        end else begin
          cur_next = rd_size;
          state_next = ST_GROW;
        end
      end
      ST_GROW: begin
        if (cur >= goal && op == CMD_ALLOC) begin
          state_next = (cur > goal) ? ST_SPLIT : ST_MARK;
        end else if (cur >= goal || nx_grow >= units) begin
          best_next = best_max;
          pos_next = pos_cur;
          state_next = ST_WALK;
        end else begin
          state_next = ST_GHDR;
        end
      end
      ST_GHDR: begin
        if (rd_used) begin
          best_next = best_max;
          pos_next = pos_cur;
          state_next = ST_WALK;
        end else begin
          cur_next = merged;
          state_next = ST_GROW;
        end
      end
      ST_SPLIT: begin
        state_next = ST_MARK;
      end
      ST_MARK: begin
        res_found_next = 1'b1;
        res_offset_next = offset_wide[OFF_W-1:0];
        state_next = ST_DONE;
      end
      ST_FWALK: begin
        state_next = (pos >= units || pos > target) ? ST_DONE : ST_FHDR;
      end
      ST_FHDR: begin
        if (pos == target) begin
          cur_next = rd_size;
          state_next = (rd_used && nx_free < units) ? ST_FNXT : ST_DONE;
        end else if (rd_size == '0) begin
          state_next = ST_DONE;
        end else begin
          pos_next = pos_rd;
          state_next = ST_FWALK;
        end
      end
      ST_FNXT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Header RAM port and status
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = pos[AW-1:0];
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wdata = {SW'(RESET_UNITS), 1'b0};
      end
      ST_IDLE: begin
        mem_we = job.cfg_we;
        mem_wdata = {cfg_units[SW-1:0], 1'b0};
      end
      ST_GROW: begin
        mem_raddr = nx_grow[AW-1:0];
      end
      ST_GHDR: begin
        mem_we = !rd_used;
        mem_waddr = pos[AW-1:0];
        mem_wdata = {merged[SW-1:0], 1'b0};
      end
      ST_SPLIT: begin
        mem_we = 1'b1;
        mem_waddr = split_at[AW-1:0];
        mem_wdata = {remain[SW-1:0], 1'b0};
      end
      ST_MARK: begin
        mem_we = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = {goal[SW-1:0], 1'b1};
      end
      ST_FHDR: begin
        mem_raddr = nx_free[AW-1:0];
        // Release in place when the block is last in the pool
        mem_we = (pos == target) && rd_used && (nx_free >= units);
        mem_waddr = pos[AW-1:0];
        mem_wdata = {rd_size[SW-1:0], 1'b0};
      end
      ST_FNXT: begin
        mem_we = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = rd_used ? {cur[SW-1:0], 1'b0} : {merged[SW-1:0], 1'b0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    status.idle = (state == ST_IDLE);
    status.res_valid = (state == ST_DONE);
    status.found = res_found;
    status.offset = res_offset;
    status.largest = res_largest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      units <= PW'(RESET_UNITS);
    end else begin
      state <= state_next;
      units <= units_next;
    end
    op <= op_next;
    pos <= pos_next;
    cur <= cur_next;
    goal <= goal_next;
    best <= best_next;
    target <= target_next;
    res_found <= res_found_next;
    res_offset <= res_offset_next;
    res_largest <= res_largest_next;
  end

endmodule

`default_nettype wire

>>> rtl/implicit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// implicit_free_list_allocator_core
// First-fit allocator over a pool of 8-byte units with in-pool block headers.
// ----------------------------------------------------------------------------
// Operation: allocate and optimize walk the headers block by block, merging runs
//   of free blocks; an allocate hit then splits off any remainder and marks the
//   block; free walks to the target block and releases it, merging a free next
//   neighbour; every result is registered into the output beat.
// Throughput: one item at a time, bounded by the single header RAM read port.
// Reset: the init state writes one header at unit 0 that makes the pool a single free block, then idle.
// ----------------------------------------------------------------------------
`default_nettype none

module implicit_free_list_allocator_core #(
  parameter int POOL_UNITS = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ifla_cmd_if.sink    cmd,
  ifla_rsp_if.source  rsp,
  ifla_cfg_if.sink    cfg
);
  import ifla_pkg::*;

  job_t job;
  status_t status;
  logic res_take;
  logic rsp_valid;
  logic rsp_found;
  logic [OFF_W-1:0] rsp_offset;
  logic [LFB_W-1:0] rsp_largest;
  logic [REQ_W-1:0] req_min;
  logic [REQ_W+1:0] req_sum;

  // Zero bytes is served as one byte
  assign req_min = (cmd.request_bytes == '0) ? REQ_W'(1) : cmd.request_bytes;
  assign req_sum = (REQ_W+2)'(req_min) + (REQ_W+2)'(2 * UNIT_BYTES - 1);

  assign cfg.ready = status.idle;
  assign cmd.ready = status.idle && !cfg.valid;

  assign job.cfg_we = cfg.valid && cfg.ready;
  assign job.pool_bytes = cfg.pool_bytes;
  assign job.start = cmd.valid && cmd.ready;
  assign job.command = cmd.command;
  assign job.need = NEED_W'(req_sum >> UNIT_SHIFT);
  assign job.target = cmd.payload_offset[OFF_W-1:UNIT_SHIFT] - TGT_W'(1);
  assign job.target_ok = (cmd.payload_offset[UNIT_SHIFT-1:0] == '0) &&
                         (cmd.payload_offset[OFF_W-1:UNIT_SHIFT] != '0);

  assign res_take = !rsp_valid || rsp.ready;

  ifla_walker #(
    .POOL_UNITS (POOL_UNITS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .res_take (res_take),
    .status   (status)
  );

  // Hold the result beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (status.res_valid && res_take) begin
      rsp_found <= status.found;
      rsp_offset <= status.offset;
      rsp_largest <= status.largest;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.found = rsp_found;
  assign rsp.granted_offset = rsp_offset;
  assign rsp.largest_free_bytes = rsp_largest;

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit allocator core. It keeps its own
// header map of the pool and predicts every result. It runs a directed set of
// corner cases, then random allocate/free/optimize traffic over several pool
// sizes, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import ifla_pkg::*;

  localparam int POOL_UNITS = 4096;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int QUIET_LIMIT = 200000;
  localparam int LONG_HOLD_AT = 450;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
    bit release_live;
  } alloc_op_t;

  typedef struct packed {
    logic found;
    logic [OFF_W-1:0] granted_offset;
    logic [LFB_W-1:0] largest_free_bytes;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst;

  ifla_cmd_if cmd_ch ();
  ifla_rsp_if rsp_ch ();
  ifla_cfg_if cfg_ch ();

  implicit_free_list_allocator_core #(
    .POOL_UNITS(POOL_UNITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Header map: {size_in_units, allocated}, meaningful at block starts only
  logic [13:0] hdr_mem [POOL_UNITS];
  int unsigned pool_units;

  alloc_op_t cmd_q[$];
  alloc_rsp_t rsp_q[$];
  alloc_op_t cur_op;

  int snd_gap_max = 0;
  int rcv_gap_max = 0;
  int snd_wait;
  int rcv_wait;
  int rsp_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic int unsigned blk_units(int unsigned p);
    return 32'(hdr_mem[p][13:1]);
  endfunction

  function automatic bit blk_used(int unsigned p);
    return hdr_mem[p][0];
  endfunction

  function automatic void hdr_put(int unsigned p, int unsigned units, bit used);
    hdr_mem[p] = {units[12:0], used};
  endfunction

  function automatic void pool_format(logic [CFG_W-1:0] bytes);
    int unsigned u;
    u = 32'(bytes >> UNIT_SHIFT);
    if (u < MIN_UNITS) u = MIN_UNITS;
    if (u > POOL_UNITS) u = POOL_UNITS;
    pool_units = u;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    hdr_put(0, u, 1'b0);
  endfunction

  // Merge following free blocks into the free block at p until it reaches goal
  function automatic int unsigned absorb_free(int unsigned p, int unsigned goal);
    int unsigned sz, nx;
    sz = blk_units(p);
    while (sz < goal) begin
      nx = p + sz;
      if (nx >= pool_units || blk_used(nx)) break;
      sz += blk_units(nx);
      hdr_put(p, sz, 1'b0);
    end
    return sz;
  endfunction

  function automatic int unsigned first_fit(logic [REQ_W-1:0] req);
    int unsigned need, p, sz, r;
    r = (req == 0) ? 1 : req;
    need = (r + 2 * UNIT_BYTES - 1) / UNIT_BYTES;
    p = 0;
    while (p < pool_units) begin
      sz = blk_units(p);
      if (sz == 0) break;
      if (!blk_used(p)) begin
        sz = absorb_free(p, need);
        if (sz >= need) begin
          if (sz > need) hdr_put(p + need, sz - need, 1'b0);
          hdr_put(p, need, 1'b1);
          return p + 1;
        end
      end
      p += sz;
    end
    return 0;
  endfunction

  function automatic void release_block(logic [OFF_W-1:0] off);
    int unsigned tgt, p, sz, nx;
    if (off < UNIT_BYTES || off[UNIT_SHIFT-1:0] != '0) return;
    tgt = (off >> UNIT_SHIFT) - 1;
    p = 0;
    while (p < pool_units && p < tgt) begin
      sz = blk_units(p);
      if (sz == 0) return;
      p += sz;
    end
    if (p != tgt || p >= pool_units || !blk_used(p)) return;
    sz = blk_units(p);
    nx = p + sz;
    if (nx < pool_units && !blk_used(nx)) sz += blk_units(nx);
    hdr_put(p, sz, 1'b0);
  endfunction

  function automatic logic [LFB_W-1:0] coalesce_all();
    int unsigned p, sz, best;
    p = 0;
    best = 0;
    while (p < pool_units) begin
      sz = blk_units(p);
      if (sz == 0) break;
      if (!blk_used(p)) begin
        sz = absorb_free(p, pool_units);
        if (sz > best) best = sz;
      end
      p += sz;
    end
    return LFB_W'(best * UNIT_BYTES);
  endfunction

  function automatic alloc_rsp_t alloc_step(alloc_op_t op);
    alloc_rsp_t r;
    int unsigned u;
    r = '0;
    case (op.command)
      CMD_ALLOC: begin
        u = first_fit(op.request_bytes);
        if (u != 0) begin
          r.found = 1'b1;
          r.granted_offset = OFF_W'(u * UNIT_BYTES);
        end
      end
      CMD_FREE: release_block(op.payload_offset);
      CMD_OPTIMIZE: r.largest_free_bytes = coalesce_all();
      default: ;
    endcase
    return r;
  endfunction

  // Payload offset of a randomly chosen allocated block, or noise if none
  function automatic logic [OFF_W-1:0] live_offset();
    int unsigned p, sz;
    int unsigned starts[$];
    p = 0;
    while (p < pool_units) begin
      sz = blk_units(p);
      if (sz == 0) break;
      if (blk_used(p)) starts.push_back(p);
      p += sz;
    end
    if (starts.size() == 0) return OFF_W'($urandom_range(1, pool_units) * UNIT_BYTES);
    return OFF_W'((starts[$urandom_range(0, starts.size() - 1)] + 1) * UNIT_BYTES);
  endfunction

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      snd_wait = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        rsp_q.push_back(alloc_step(cur_op));
        snd_wait = $urandom_range(0, snd_gap_max);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (snd_wait > 0) begin
          snd_wait--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_op = cmd_q.pop_front();
          if (cur_op.release_live) cur_op.payload_offset = live_offset();
          cmd_ch.valid <= 1'b1;
          cmd_ch.command <= cur_op.command;
          cmd_ch.request_bytes <= cur_op.request_bytes;
          cmd_ch.payload_offset <= cur_op.payload_offset;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : rsp_monitor
    alloc_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0d offset=%0d largest=%0d",
                     rsp_ch.found, rsp_ch.granted_offset, rsp_ch.largest_free_bytes);
        end else begin
          want = rsp_q.pop_front();
          if (rsp_ch.found !== want.found ||
              rsp_ch.granted_offset !== want.granted_offset ||
              rsp_ch.largest_free_bytes !== want.largest_free_bytes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected found=%0d offset=%0d largest=%0d, got %0d %0d %0d",
                       rsp_seen, want.found, want.granted_offset, want.largest_free_bytes,
                       rsp_ch.found, rsp_ch.granted_offset, rsp_ch.largest_free_bytes);
          end
        end
        // hold off once for long enough to back the block up
        rcv_wait = (rsp_seen == LONG_HOLD_AT) ? LONG_HOLD : $urandom_range(0, rcv_gap_max);
      end
      if (rcv_wait > 0) begin
        rcv_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any beat
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("implicit_free_list_allocator_core: mismatch");
        $finish;
      end
    end
  end

  task automatic push_op(logic [CMD_W-1:0] c, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    alloc_op_t op;
    op.command = c;
    op.request_bytes = req;
    op.payload_offset = off;
    op.release_live = 1'b0;
    cmd_q.push_back(op);
  endtask

  task automatic drain_wait();
    do @(negedge clk);
    while (cmd_q.size() != 0 || cmd_ch.valid || rsp_q.size() != 0);
  endtask

  task automatic write_pool(logic [CFG_W-1:0] bytes);
    drain_wait();
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_ch.pool_bytes <= bytes;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    pool_format(bytes);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_ops(int n, int req_max);
    alloc_op_t op;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      op.command = CMD_ALLOC;
      op.request_bytes = REQ_W'($urandom());
      op.payload_offset = OFF_W'($urandom());
      op.release_live = 1'b0;
      if (pick < 45) begin
        case ($urandom_range(0, 19))
          0: ;
          1: op.request_bytes = '0;
          default: op.request_bytes = REQ_W'($urandom_range(0, req_max));
        endcase
      end else if (pick < 80) begin
        op.command = CMD_FREE;
        op.release_live = 1'b1;
      end else if (pick < 88) begin
        op.command = CMD_FREE;
        if ($urandom_range(0, 1))
          op.payload_offset = OFF_W'($urandom_range(1, 4095) << UNIT_SHIFT);
      end else if (pick < 96) begin
        op.command = CMD_OPTIMIZE;
      end else begin
        op.command = CMD_RESERVED;
      end
      cmd_q.push_back(op);
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] bytes, int n, int req_max, int snd_max,
                           int rcv_max);
    write_pool(bytes);
    snd_gap_max = snd_max;
    rcv_gap_max = rcv_max;
    fill_ops(n, req_max);
  endtask

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_ALLOC;
    cmd_ch.request_bytes = '0;
    cmd_ch.payload_offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pool_bytes = '0;
    pool_format(CFG_W'(POOL_BYTES_RESET));
    snd_gap_max = 2;
    rcv_gap_max = 2;

    // Corner cases on the reset pool
    push_op(CMD_ALLOC, 15'd0, 15'd0);
    push_op(CMD_ALLOC, 15'd1, 15'h7fff);
    push_op(CMD_ALLOC, 15'd8, 15'd0);
    push_op(CMD_ALLOC, 15'd9, 15'd0);
    push_op(CMD_ALLOC, 15'h7fff, 15'd0);
    push_op(CMD_ALLOC, 15'd32760, 15'd0);
    push_op(CMD_FREE, 15'h7fff, 15'd24);
    push_op(CMD_FREE, 15'd0, 15'd24);
    push_op(CMD_FREE, 15'd0, 15'd0);
    push_op(CMD_FREE, 15'd0, 15'd12);
    push_op(CMD_FREE, 15'd0, 15'd16);
    push_op(CMD_FREE, 15'd0, 15'h7fff);
    push_op(CMD_FREE, 15'd0, 15'd32760);
    push_op(CMD_FREE, 15'd0, 15'd40);
    // merge on allocate, leaving a header-only remainder
    push_op(CMD_ALLOC, 15'd9, 15'd0);
    push_op(CMD_ALLOC, 15'd0, 15'd0);
    push_op(CMD_FREE, 15'd0, 15'd56);
    push_op(CMD_FREE, 15'd0, 15'd24);
    push_op(CMD_OPTIMIZE, 15'd0, 15'd0);
    push_op(CMD_RESERVED, 15'h7fff, 15'h7fff);
    push_op(CMD_FREE, 15'd0, 15'd8);
    push_op(CMD_FREE, 15'd0, 15'd80);
    push_op(CMD_OPTIMIZE, 15'h7fff, 15'h7fff);
    push_op(CMD_ALLOC, 15'd32760, 15'd0);
    push_op(CMD_OPTIMIZE, 15'd0, 15'd0);
    push_op(CMD_FREE, 15'd0, 15'd8);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    run_phase(16'd16, 20, 16, 16, 16);
    run_phase(16'd0, 10, 8, 0, 0);
    run_phase(16'hffff, 120, 2048, 0, 0);
    run_phase(CFG_W'($urandom_range(64, 2048)), 100, 200, 16, 16);
    // pause the sender until everything has come back
    drain_wait();
    fill_ops(100, 200);
    run_phase(16'd23, 10, 16, 2, 2);
    run_phase(16'd32768, 150, 64, 3, 3);
    run_phase(CFG_W'($urandom_range(16, 40000)), 200, 4000, 5, 16);
    run_phase(16'd512, 250, 48, 16, 0);
    run_phase(16'd4096, 180, 300, 0, 16);

    drain_wait();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && rsp_q.size() == 0) begin
      $display("implicit_free_list_allocator_core: match");
    end else begin
      $display("implicit_free_list_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ifla_pkg.sv
rtl/ifla_if.sv
rtl/ifla_ram.sv
rtl/ifla_walker.sv
rtl/implicit_free_list_allocator_core.sv
verif/tb.sv
